[hdl/dctm_pkg.sv]
// Shared types and constants for the dual-channel trimmed-mean filter.
`timescale 1ns / 1ps

package dctm_pkg;

  localparam int CODE_W = 12;

  typedef logic [CODE_W-1:0] code_t;

  localparam code_t CODE_ONES = '1;

  typedef struct packed {
    logic load;
    logic close;
  } acc_ctl_t;

endpackage

[hdl/dctm_chan_acc.sv]
// Per-channel running sum, minimum and maximum with frame-close capture.
`timescale 1ns / 1ps

module dctm_chan_acc
  import dctm_pkg::*;
#(
  parameter int SUM_W = 15
) (
  input  logic             clk,
  input  logic             rst_n,
  input  acc_ctl_t         ctl,
  input  code_t            code,
  output logic [SUM_W-1:0] tot_sum,
  output code_t            tot_lo,
  output code_t            tot_hi
);

  logic [SUM_W-1:0] sum_r, sum_nxt;
  code_t            lo_r, lo_nxt;
  code_t            hi_r, hi_nxt;
  logic [SUM_W-1:0] tot_sum_r;
  code_t            tot_lo_r;
  code_t            tot_hi_r;

  always_comb begin
    sum_nxt = sum_r;
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    if (ctl.load) begin
      sum_nxt = sum_r + SUM_W'(code);
      if (code < lo_r) begin
        lo_nxt = code;
      end
      if (code > hi_r) begin
        hi_nxt = code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.close) begin
      sum_r <= '0;
      lo_r  <= CODE_ONES;
      hi_r  <= '0;
    end else begin
      sum_r <= sum_nxt;
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
    end
  end

  // capture frame totals
  always_ff @(posedge clk) begin
    if (ctl.close) begin
      tot_sum_r <= sum_nxt;
      tot_lo_r  <= lo_nxt;
      tot_hi_r  <= hi_nxt;
    end
  end

  assign tot_sum = tot_sum_r;
  assign tot_lo  = tot_lo_r;
  assign tot_hi  = tot_hi_r;

endmodule

[hdl/dctm_trim_div.sv]
// Trim the extremes from a frame sum and divide by a constant via reciprocal multiply.
`timescale 1ns / 1ps

module dctm_trim_div
  import dctm_pkg::*;
#(
  parameter int SUM_W  = 15,
  parameter int REST_W = 15,
  parameter int DIV    = 6
) (
  input  logic             clk,
  input  logic             en,
  input  logic [SUM_W-1:0] sum,
  input  code_t            lo,
  input  code_t            hi,
  output code_t            quot
);

  localparam int LOG_D  = $clog2(DIV);
  localparam int SHIFT  = REST_W + LOG_D;
  localparam int MUL_W  = REST_W + 1;
  localparam int PROD_W = REST_W + MUL_W;
  localparam longint unsigned MULT = ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);

  logic [SUM_W-1:0]  rest_full;
  logic [REST_W-1:0] rest_r;
  logic [PROD_W-1:0] prod_nxt;
  logic [PROD_W-1:0] prod_r;

  assign rest_full = sum - SUM_W'(lo) - SUM_W'(hi);
  assign prod_nxt  = PROD_W'(rest_r) * PROD_W'(MULT);

  always_ff @(posedge clk) begin
    if (en) begin
      rest_r <= rest_full[REST_W-1:0];
      prod_r <= prod_nxt;
    end
  end

  assign quot = prod_r[SHIFT +: CODE_W];

endmodule

[hdl/dual_channel_trimmed_mean.sv]
// Top level of the dual-channel trimmed-mean filter.
`timescale 1ns / 1ps

// Takes one 12-bit ADC word per cycle, alternating battery then motor, and after
// 2*SAMPLES_PER_CHANNEL words gives one result word holding both channels' means
// with one minimum and one maximum dropped, truncated. out_valid rises after the
// edge that accepts the last word of a frame: totals are captured on that edge,
// then come trim, reciprocal multiply and the output register. A word
// is accepted every cycle, even while a result waits unread; the input stalls only
// when the next frame's result is ready to enter the output register and the
// previous result is still held there unread.
module dual_channel_trimmed_mean
  import dctm_pkg::*;
#(
  parameter int SAMPLES_PER_CHANNEL = 8
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  code_t in_sample,
  output logic  out_valid,
  input  logic  out_ready,
  output code_t out_battery_mean,
  output code_t out_motor_mean
);

  localparam int FRAME_LEN = 2 * SAMPLES_PER_CHANNEL;
  localparam int POS_W     = $clog2(FRAME_LEN);
  localparam int SUM_W     = $clog2(SAMPLES_PER_CHANNEL * 4095 + 1);
  localparam int DIV       = SAMPLES_PER_CHANNEL - 2;
  localparam int REST_W    = $clog2(DIV * 4095 + 1);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

  logic             en;
  logic             accept;
  logic             last;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             tot_v_r, rest_v_r, prod_v_r, out_valid_r;
  code_t            bat_mean_r, mot_mean_r;
  acc_ctl_t         bat_ctl, mot_ctl;
  logic [SUM_W-1:0] bat_sum, mot_sum;
  code_t            bat_lo, bat_hi, mot_lo, mot_hi;
  code_t            bat_quot, mot_quot;

  assign en     = !(prod_v_r && out_valid_r && !out_ready);
  assign accept = in_valid && en;
  assign last   = (pos_r == LAST_POS);

  assign pos_nxt = last ? '0 : pos_r + POS_W'(1);

  assign bat_ctl.load  = accept && !pos_r[0];
  assign bat_ctl.close = accept && last;
  assign mot_ctl.load  = accept && pos_r[0];
  assign mot_ctl.close = accept && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      tot_v_r     <= 1'b0;
      rest_v_r    <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        if (accept) begin
          pos_r <= pos_nxt;
        end
        tot_v_r  <= accept && last;
        rest_v_r <= tot_v_r;
        prod_v_r <= rest_v_r;
      end
      if (en && prod_v_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && prod_v_r) begin
      bat_mean_r <= bat_quot;
      mot_mean_r <= mot_quot;
    end
  end

  dctm_chan_acc #(.SUM_W(SUM_W)) u_bat_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (bat_ctl),
    .code    (in_sample),
    .tot_sum (bat_sum),
    .tot_lo  (bat_lo),
    .tot_hi  (bat_hi)
  );

  dctm_chan_acc #(.SUM_W(SUM_W)) u_mot_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mot_ctl),
    .code    (in_sample),
    .tot_sum (mot_sum),
    .tot_lo  (mot_lo),
    .tot_hi  (mot_hi)
  );

  dctm_trim_div #(.SUM_W(SUM_W), .REST_W(REST_W), .DIV(DIV)) u_bat_div (
    .clk  (clk),
    .en   (en),
    .sum  (bat_sum),
    .lo   (bat_lo),
    .hi   (bat_hi),
    .quot (bat_quot)
  );

  dctm_trim_div #(.SUM_W(SUM_W), .REST_W(REST_W), .DIV(DIV)) u_mot_div (
    .clk  (clk),
    .en   (en),
    .sum  (mot_sum),
    .lo   (mot_lo),
    .hi   (mot_hi),
    .quot (mot_quot)
  );

  assign in_ready         = en;
  assign out_valid        = out_valid_r;
  assign out_battery_mean = bat_mean_r;
  assign out_motor_mean   = mot_mean_r;

endmodule
